[rtl/core/mlsp_pkg.sv]
// package for the metric label set parser
// types, codes and character class helpers shared by the modules
// no dependencies
package mlsp_pkg;

  localparam int MaxLabelsDefault = 64;

  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChComma     = 8'h2c;
  localparam logic [7:0] ChEq        = 8'h3d;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChUnder     = 8'h5f;
  localparam logic [7:0] ChLbrace    = 8'h7b;
  localparam logic [7:0] ChRbrace    = 8'h7d;

  typedef enum logic [3:0] {
    GS_START        = 4'd0,
    GS_AFTER_NAME   = 4'd1,
    GS_KEY_OR_CLOSE = 4'd2,
    GS_EXPECT_EQ    = 4'd3,
    GS_EXPECT_QUOTE = 4'd4,
    GS_EXPECT_COMMA = 4'd5,
    GS_DONE         = 4'd6
  } gs_t;

  typedef enum logic [1:0] {
    LM_BETWEEN = 2'd0,
    LM_IDENT   = 2'd1,
    LM_QUOTED  = 2'd2,
    LM_ESCAPED = 2'd3
  } lm_t;

  typedef enum logic [1:0] {
    ST_BUSY     = 2'd0,
    ST_OK       = 2'd1,
    ST_SYNTAX   = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ROLE_NONE  = 2'd0,
    ROLE_NAME  = 2'd1,
    ROLE_KEY   = 2'd2,
    ROLE_VALUE = 2'd3
  } role_t;

  typedef struct packed {
    gs_t     gs;
    lm_t     lm;
    status_t err;
  } parse_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    role_t      role;
    logic [5:0] label_index;
    status_t    status;
    logic       text_end;
  } result_t;

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
  endfunction

  function automatic logic is_ident_tail(input logic [7:0] c);
    return is_letter(c) || (c inside {[8'h30:8'h39]}) || (c == ChUnder);
  endfunction

endpackage

[rtl/core/mlsp_if.sv]
// valid/ready channel interfaces for the metric label set parser
// mlsp_in_if carries one text byte, mlsp_out_if one result item; no dependencies
interface mlsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

interface mlsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] role;
  logic [5:0] label_index;
  logic [1:0] status;
  logic       text_end;

  modport source (output valid, output out_byte, output role, output label_index,
                  output status, output text_end, input ready);
  modport sink (input valid, input out_byte, input role, input label_index,
                input status, input text_end, output ready);
endinterface

[rtl/core/mlsp_step.sv]
// per-byte grammar and lexer decision of the metric label set parser
// next state and result for one byte; depends on mlsp_pkg
module mlsp_step #(
  parameter int MAX_LABELS = mlsp_pkg::MaxLabelsDefault,
  parameter int CNT_W      = $clog2(MAX_LABELS + 1)
) (
  input  logic [7:0]             char_byte,
  input  mlsp_pkg::parse_state_t st,
  input  logic [CNT_W-1:0]       cnt,
  output mlsp_pkg::parse_state_t st_nxt,
  output logic [CNT_W-1:0]       cnt_nxt,
  output mlsp_pkg::result_t      res
);
  import mlsp_pkg::*;

  logic at_end;
  logic handled;
  logic bad;

  assign at_end = (char_byte == ChNul);

  always_comb begin
    st_nxt          = st;
    cnt_nxt         = cnt;
    handled         = 1'b0;
    bad             = 1'b0;
    res.out_byte    = 8'h00;
    res.role        = ROLE_NONE;
    res.label_index = 6'(cnt);
    res.status      = ST_BUSY;
    res.text_end    = at_end;

    if (st.err != ST_BUSY) begin
      res.status = st.err;
    end else if (st.gs == GS_DONE) begin
      res.status = ST_OK;
    end else begin
      case (st.lm)
        LM_IDENT: begin
          if (is_ident_tail(char_byte)) begin
            res.role     = (st.gs == GS_AFTER_NAME) ? ROLE_NAME : ROLE_KEY;
            res.out_byte = char_byte;
            handled      = 1'b1;
          end else begin
            st_nxt.lm = LM_BETWEEN;
          end
        end
        LM_QUOTED: begin
          handled = 1'b1;
          if (at_end) begin
            st_nxt.err = ST_SYNTAX;
          end else if (char_byte == ChQuote) begin
            st_nxt.lm = LM_BETWEEN;
            st_nxt.gs = GS_EXPECT_COMMA;
            cnt_nxt   = cnt + CNT_W'(1);
          end else if (char_byte == ChBackslash) begin
            st_nxt.lm = LM_ESCAPED;
          end else begin
            res.role     = ROLE_VALUE;
            res.out_byte = char_byte;
          end
        end
        LM_ESCAPED: begin
          handled = 1'b1;
          if (at_end) begin
            st_nxt.err = ST_SYNTAX;
          end else begin
            res.role     = ROLE_VALUE;
            res.out_byte = char_byte;
            st_nxt.lm    = LM_QUOTED;
          end
        end
        default: begin
        end
      endcase

      if (!handled && char_byte != ChSpace) begin
        case (st.gs)
          GS_START: begin
            if (is_letter(char_byte)) begin
              st_nxt.lm    = LM_IDENT;
              st_nxt.gs    = GS_AFTER_NAME;
              res.role     = ROLE_NAME;
              res.out_byte = char_byte;
            end else if (char_byte == ChLbrace) begin
              st_nxt.gs = GS_KEY_OR_CLOSE;
            end else begin
              bad = 1'b1;
            end
          end
          GS_AFTER_NAME: begin
            if (char_byte == ChLbrace) begin
              st_nxt.gs = GS_KEY_OR_CLOSE;
            end else if (at_end) begin
              res.status = ST_OK;
            end else begin
              bad = 1'b1;
            end
          end
          GS_KEY_OR_CLOSE: begin
            if (char_byte == ChRbrace) begin
              st_nxt.gs = GS_DONE;
            end else if (is_letter(char_byte)) begin
              if (cnt >= CNT_W'(MAX_LABELS)) begin
                st_nxt.err = ST_OVERFLOW;
              end else begin
                st_nxt.lm    = LM_IDENT;
                st_nxt.gs    = GS_EXPECT_EQ;
                res.role     = ROLE_KEY;
                res.out_byte = char_byte;
              end
            end else begin
              bad = 1'b1;
            end
          end
          GS_EXPECT_EQ: begin
            if (char_byte == ChEq) begin
              st_nxt.gs = GS_EXPECT_QUOTE;
            end else begin
              bad = 1'b1;
            end
          end
          GS_EXPECT_QUOTE: begin
            if (char_byte == ChQuote) begin
              st_nxt.lm = LM_QUOTED;
            end else begin
              bad = 1'b1;
            end
          end
          GS_EXPECT_COMMA: begin
            if (char_byte == ChComma) begin
              st_nxt.gs = GS_KEY_OR_CLOSE;
            end else if (char_byte == ChRbrace) begin
              st_nxt.gs = GS_DONE;
            end else begin
              bad = 1'b1;
            end
          end
          default: begin
            bad = 1'b1;
          end
        endcase
        if (bad) begin
          st_nxt.err = ST_SYNTAX;
        end
      end

      if (st_nxt.err != ST_BUSY) begin
        res.status   = st_nxt.err;
        res.role     = ROLE_NONE;
        res.out_byte = 8'h00;
      end else if (st_nxt.gs == GS_DONE) begin
        res.status = ST_OK;
      end
    end

    // terminator restarts the parser
    if (at_end) begin
      st_nxt.gs  = GS_START;
      st_nxt.lm  = LM_BETWEEN;
      st_nxt.err = ST_BUSY;
      cnt_nxt    = '0;
    end
  end

endmodule

[rtl/core/metric_label_set_parser.sv]
// metric label set parser: one byte in, one result item out
// an accepted byte passes the input register, the step decision and the result register; one item per cycle
// while the output is not stalled, since the step decision between the two registers is combinational
// synchronous active-low reset returns the parser to the start state and empties both stages
// depends on mlsp_pkg, mlsp_if and mlsp_step
module metric_label_set_parser #(
  parameter int MAX_LABELS = mlsp_pkg::MaxLabelsDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  mlsp_in_if.sink           in_ch,
  mlsp_out_if.source        out_ch
);
  import mlsp_pkg::*;

  localparam int CntW = $clog2(MAX_LABELS + 1);

  logic           in_valid_r;
  logic [7:0]     in_byte_r;
  logic           out_valid_r;
  result_t        res_r;
  parse_state_t   st_r;
  parse_state_t   st_nxt;
  logic [CntW-1:0] cnt_r;
  logic [CntW-1:0] cnt_nxt;
  result_t        res_nxt;
  logic           advance;

  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  mlsp_step #(
    .MAX_LABELS (MAX_LABELS),
    .CNT_W      (CntW)
  ) u_step (
    .char_byte (in_byte_r),
    .st        (st_r),
    .cnt       (cnt_r),
    .st_nxt    (st_nxt),
    .cnt_nxt   (cnt_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r.gs     <= GS_START;
      st_r.lm     <= LM_BETWEEN;
      st_r.err    <= ST_BUSY;
      cnt_r       <= '0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
        cnt_r       <= cnt_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.char_byte;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = res_r.out_byte;
  assign out_ch.role        = res_r.role;
  assign out_ch.label_index = res_r.label_index;
  assign out_ch.status      = res_r.status;
  assign out_ch.text_end    = res_r.text_end;

endmodule
